### sv/lge_pkg.sv
package lge_pkg;

  // Default grid size
  localparam int DEF_GRID_COLS = 256;
  localparam int DEF_GRID_ROWS = 128;

  // Field widths of the item ports
  localparam int KIND_W = 2;
  localparam int ROW_W  = 7;
  localparam int COL_W  = 8;

  // Configuration port
  localparam int CFG_COLS_W  = 9;
  localparam int CFG_ROWS_W  = 8;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 1'b1;

  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 9'd200;
  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 8'd100;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  // B3/S23 rule
  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CELL  = 5'b00100,
    S_GEN   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

### sv/lge_row_mem.sv
module lge_row_mem #(
  parameter int DEPTH = lge_pkg::DEF_GRID_ROWS,
  parameter int WIDTH = lge_pkg::DEF_GRID_COLS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one row, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lge_rule.sv
module lge_rule #(
  parameter int COLS = lge_pkg::DEF_GRID_COLS
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] center,
  input  logic [COLS-1:0] below,
  input  logic [COLS-1:0] col_mask,
  output logic [COLS-1:0] next_row
);

  // Pad each row with a dead cell on both ends
  logic [COLS+1:0] pad_above;
  logic [COLS+1:0] pad_center;
  logic [COLS+1:0] pad_below;

  assign pad_above  = {1'b0, above, 1'b0};
  assign pad_center = {1'b0, center, 1'b0};
  assign pad_below  = {1'b0, below, 1'b0};

  // Count the eight neighbors of each cell and apply birth and survival
  for (genvar i = 0; i < COLS; i++) begin : g_cell
    logic [lge_pkg::NBR_W-1:0] count;

    assign count = lge_pkg::NBR_W'(pad_above[i]) + lge_pkg::NBR_W'(pad_above[i+1])
                 + lge_pkg::NBR_W'(pad_above[i+2]) + lge_pkg::NBR_W'(pad_center[i])
                 + lge_pkg::NBR_W'(pad_center[i+2]) + lge_pkg::NBR_W'(pad_below[i])
                 + lge_pkg::NBR_W'(pad_below[i+1]) + lge_pkg::NBR_W'(pad_below[i+2]);

    assign next_row[i] = col_mask[i] & ((count == lge_pkg::BIRTH_COUNT)
                       | (center[i] & (count == lge_pkg::SURVIVE_COUNT)));
  end

endmodule

### sv/life_generation_engine_unit.sv
// Game of Life engine (rule B3/S23) over a grid of up to GRID_ROWS x GRID_COLS cells,
// double buffered in two row-wide banks; cells outside the region in use count as dead.
// After reset the block clears both banks, one row a cycle, and takes no word in
// that time. A read or write word passes through these steps once taken: the row is
// read at the accepting edge, then modified and written back, then the result register
// is loaded; the block takes the next word once that result is registered. An advance
// word reads the old bank, which delivers one row per cycle through its single read
// port, and each new row is written in the same cycle as the row below it arrives.
// One word is in work at a time; the result register frees the output side.
module life_generation_engine_unit #(
  parameter int GRID_COLS = lge_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = lge_pkg::DEF_GRID_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lge_pkg::KIND_W-1:0]      kind,
  input  logic [lge_pkg::ROW_W-1:0]       row,
  input  logic [lge_pkg::COL_W-1:0]       column,
  input  logic                            value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            cell_value,
  output logic [lge_pkg::KIND_W-1:0]      done_kind,
  input  logic                            cfg_we,
  input  logic [lge_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lge_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CIW = $clog2(GRID_COLS);
  localparam int CUW = $clog2(GRID_COLS + 1);
  localparam int RUW = $clog2(GRID_ROWS + 1);
  localparam int SW  = $clog2(GRID_ROWS + 2);

  lge_pkg::state_t state;

  logic [lge_pkg::CFG_COLS_W-1:0] cols_cfg;
  logic [lge_pkg::CFG_ROWS_W-1:0] rows_cfg;
  logic [CUW-1:0]                 cols_use;
  logic [RUW-1:0]                 rows_use;
  logic [GRID_COLS-1:0]           col_mask;

  logic [SW-1:0]  step;
  logic           cur;
  logic           accept;
  logic           in_region;
  logic           out_free;

  logic [lge_pkg::KIND_W-1:0] pend_kind;
  logic [RW-1:0]              pend_row;
  logic [CIW-1:0]             pend_col;
  logic                       pend_value;
  logic                       pend_inside;
  logic                       pend_cell;

  logic                 rd_en;
  logic [RW-1:0]        rd_addr;
  logic [GRID_COLS-1:0] rd_a;
  logic [GRID_COLS-1:0] rd_b;
  logic [GRID_COLS-1:0] rd_row;
  logic                 wa_en;
  logic                 wb_en;
  logic [RW-1:0]        wr_addr;
  logic [GRID_COLS-1:0] wr_data;
  logic [GRID_COLS-1:0] patched_row;

  logic [GRID_COLS-1:0] row_above;
  logic [GRID_COLS-1:0] row_center;
  logic [GRID_COLS-1:0] below;
  logic [GRID_COLS-1:0] rule_row;
  logic [GRID_COLS-1:0] gen_data;

  // Saturate the region size to 1..grid size
  always_comb begin
    if (cols_cfg == '0) begin
      cols_use = CUW'(1);
    end else if (32'(cols_cfg) > GRID_COLS) begin
      cols_use = CUW'(GRID_COLS);
    end else begin
      cols_use = CUW'(cols_cfg);
    end
  end

  always_comb begin
    if (rows_cfg == '0) begin
      rows_use = RUW'(1);
    end else if (32'(rows_cfg) > GRID_ROWS) begin
      rows_use = RUW'(GRID_ROWS);
    end else begin
      rows_use = RUW'(rows_cfg);
    end
  end

  for (genvar i = 0; i < GRID_COLS; i++) begin : g_mask
    assign col_mask[i] = (32'(cols_use) > i);
  end

  assign in_ready  = (state == lge_pkg::S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = !out_valid || out_ready;
  assign in_region = (32'(row) < 32'(rows_use)) && (32'(column) < 32'(cols_use));

  // Row banks
  lge_row_mem #(.DEPTH(GRID_ROWS), .WIDTH(GRID_COLS)) u_bank_a (
    .clk  (clk),
    .we   (wa_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_a)
  );

  lge_row_mem #(.DEPTH(GRID_ROWS), .WIDTH(GRID_COLS)) u_bank_b (
    .clk  (clk),
    .we   (wb_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_b)
  );

  assign rd_row = cur ? rd_b : rd_a;

  // Issue row reads: the cell's row on a read or write, one row per cycle on advance
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept && in_region &&
        (kind == lge_pkg::KIND_READ || kind == lge_pkg::KIND_WRITE)) begin
      rd_en   = 1'b1;
      rd_addr = RW'(row);
    end else if (state == lge_pkg::S_GEN && 32'(step) < GRID_ROWS) begin
      rd_en   = 1'b1;
      rd_addr = RW'(step);
    end
  end

  // Arriving old row, dead outside the region
  always_comb begin
    if (step != '0 && 32'(step) <= 32'(rows_use)) begin
      below = rd_row & col_mask;
    end else begin
      below = '0;
    end
  end

  lge_rule #(.COLS(GRID_COLS)) u_rule (
    .above   (row_above),
    .center  (row_center),
    .below   (below),
    .col_mask(col_mask),
    .next_row(rule_row)
  );

  // New row step-2 lies in the region or is cleared
  assign gen_data = (32'(step) <= 32'(rows_use) + 32'd1) ? rule_row : '0;

  // Patch one cell into the row just read
  always_comb begin
    patched_row           = rd_row;
    patched_row[pend_col] = pend_value;
  end

  // Drive the bank write ports
  always_comb begin
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      lge_pkg::S_CLEAR: begin
        wa_en   = 1'b1;
        wb_en   = 1'b1;
        wr_addr = RW'(step);
      end
      lge_pkg::S_CELL: begin
        if (pend_kind == lge_pkg::KIND_WRITE && pend_inside) begin
          wa_en   = !cur;
          wb_en   = cur;
          wr_addr = pend_row;
          wr_data = patched_row;
        end
      end
      lge_pkg::S_GEN: begin
        if (step >= SW'(2)) begin
          wa_en   = cur;
          wb_en   = !cur;
          wr_addr = RW'(step - SW'(2));
          wr_data = gen_data;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lge_pkg::S_CLEAR;
      step      <= '0;
      cur       <= 1'b0;
      out_valid <= 1'b0;
      cols_cfg  <= lge_pkg::COLS_RESET;
      rows_cfg  <= lge_pkg::ROWS_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lge_pkg::REG_COLS_IN_USE: cols_cfg <= lge_pkg::CFG_COLS_W'(cfg_data);
          lge_pkg::REG_ROWS_IN_USE: rows_cfg <= lge_pkg::CFG_ROWS_W'(cfg_data);
          default: ;
        endcase
      end

      // Drop the result once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        lge_pkg::S_CLEAR: begin
          step <= step + SW'(1);
          if (32'(step) == GRID_ROWS - 1) begin
            step  <= '0;
            state <= lge_pkg::S_IDLE;
          end
        end
        lge_pkg::S_IDLE: begin
          if (accept) begin
            pend_kind   <= kind;
            pend_row    <= RW'(row);
            pend_col    <= CIW'(column);
            pend_value  <= value;
            pend_inside <= in_region;
            row_above   <= '0;
            row_center  <= '0;
            step        <= '0;
            unique case (kind) inside
              lge_pkg::KIND_WRITE, lge_pkg::KIND_READ: state <= lge_pkg::S_CELL;
              lge_pkg::KIND_ADVANCE:                   state <= lge_pkg::S_GEN;
              default: ;
            endcase
          end
        end
        lge_pkg::S_CELL: begin
          pend_cell <= (pend_kind == lge_pkg::KIND_READ) & pend_inside & rd_row[pend_col];
          state     <= lge_pkg::S_DONE;
        end
        lge_pkg::S_GEN: begin
          step <= step + SW'(1);
          if (step != '0) begin
            row_above  <= row_center;
            row_center <= below;
          end
          if (32'(step) == GRID_ROWS + 1) begin
            cur       <= ~cur;
            pend_cell <= 1'b0;
            state     <= lge_pkg::S_DONE;
          end
        end
        lge_pkg::S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            cell_value <= pend_cell;
            done_kind  <= pend_kind;
            state      <= lge_pkg::S_IDLE;
          end
        end
        default: state <= lge_pkg::S_IDLE;
      endcase
    end
  end

  // The current bank changes only at the end of a generation
  a_cur_flip: assert property (@(posedge clk) disable iff (rst)
    (cur != $past(cur)) |-> $past(state == lge_pkg::S_GEN))
    else $error("current bank changed outside a generation");

  // A generation writes only the spare bank
  a_gen_target: assert property (@(posedge clk) disable iff (rst)
    (state == lge_pkg::S_GEN && (wa_en || wb_en)) |-> (wa_en == cur && wb_en == !cur))
    else $error("generation wrote the current bank");

  // A result appears only from the completion state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == lge_pkg::S_DONE))
    else $error("result raised outside completion");

endmodule
